FILE: hw/rtl/tsr_pkg.sv
// Shared constants, widths and codes for the three-shear rotation mapper.
// No dependencies; compiled first.
package tsr_pkg;

  localparam int MAX_DIM_DEF    = 2048;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_IN_W = 11;
  localparam int DIM_W      = 12;
  localparam int CROP_W     = 14;
  localparam int OUT_W      = 15;

  localparam int X0_W = 13;
  localparam int N1_W = 13;
  localparam int S1_W = 14;
  localparam int X1_W = 16;
  localparam int W1_W = 14;
  localparam int N2_W = 15;
  localparam int S2_W = 17;
  localparam int Y2_W = 17;
  localparam int H2_W = 15;
  localparam int N3_W = 16;
  localparam int S3_W = 18;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_QUADRANT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SKEW_X     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SKEW_Y     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CROP_X     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CROP_Y     = 3'd6;

  typedef enum logic [1:0] {
    QUAD_NONE = 2'd0,
    QUAD_90   = 2'd1,
    QUAD_180  = 2'd2,
    QUAD_270  = 2'd3
  } quad_t;

endpackage

FILE: hw/rtl/tsr_if.sv
// Valid/ready channels: source pixels in, mapped destinations out.
// Depends on tsr_pkg.
interface tsr_in_if #(
  parameter int PIXEL_BITS = tsr_pkg::PIXEL_BITS_DEF
);
  import tsr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_IN_W-1:0] src_x;
  logic [COORD_IN_W-1:0] src_y;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output src_x, output src_y, output pixel, input ready);
  modport sink (input valid, input src_x, input src_y, input pixel, output ready);
endinterface

interface tsr_out_if #(
  parameter int PIXEL_BITS = tsr_pkg::PIXEL_BITS_DEF
);
  import tsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  dest_x;
  logic signed [OUT_W-1:0]  dest_y;
  logic [PIXEL_BITS-1:0]    pixel_out;

  modport source (output valid, output dest_x, output dest_y, output pixel_out, input ready);
  modport sink (input valid, input dest_x, input dest_y, input pixel_out, output ready);
endinterface

FILE: hw/rtl/tsr_shear_mul.sv
// One shear multiply stage: rounded margin of a size and floored shift of a coordinate.
// Depends on tsr_pkg for the FRAC_BITS default; the other widths come from the parent.
module tsr_shear_mul #(
  parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF,
  parameter int SIZE_W    = 12,
  parameter int COORD_W   = 13,
  parameter int MARGIN_W  = 13,
  parameter int SHIFT_W   = 14
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [SIZE_W-1:0]          size,
  input  logic signed [COORD_W-1:0]  coord,
  input  logic [FRAC_BITS:0]         skew,
  output logic [MARGIN_W-1:0]        margin_r,
  output logic signed [SHIFT_W-1:0]  shift_r
);
  localparam int CP_W = COORD_W + FRAC_BITS + 2;
  localparam int SP_W = SIZE_W + FRAC_BITS + 2;

  logic signed [CP_W-1:0] coord_prod;
  logic [SP_W-1:0]        size_prod;
  logic [MARGIN_W-1:0]    margin_nxt;
  logic signed [SHIFT_W-1:0] shift_nxt;

  assign coord_prod = CP_W'(coord) * CP_W'($signed({1'b0, skew}));
  assign size_prod  = SP_W'(size) * SP_W'(skew) + (SP_W'(1) << (FRAC_BITS - 1));
  assign margin_nxt = MARGIN_W'(size_prod >> FRAC_BITS);
  assign shift_nxt  = SHIFT_W'(coord_prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      margin_r <= margin_nxt;
      shift_r  <= shift_nxt;
    end
  end
endmodule

FILE: hw/rtl/three_shear_rotation_mapper.sv
// Three-shear rotation mapper: quarter-turn, X/Y/X shears, crop offset.
// Depends on tsr_pkg, tsr_if (tsr_in_if, tsr_out_if) and tsr_shear_mul.
//
// Use: each transfer on in_px carries one source pixel (src_x, src_y, pixel).
// For each one, exactly one transfer on out_px carries the destination column
// and row relative to the crop origin (15-bit two's complement, wrapping) and
// the unchanged pixel. Results leave in input order; out-of-window results are
// not suppressed.
// Path: an input transfer loads stage 1, and the pixel moves stage by stage to the
// output register in stage 7, whose valid bit drives out_px.valid.
// Throughput: one pixel per cycle while out_px.ready stays high; the seven register
// stages each carry a valid bit, and three of them hold the shear multiplies.
// Stall: a stage loads whenever it is empty or the next one moves, so bubbles
// close up while out_px.ready is low; in_px.ready falls only once all seven
// stages hold pixels. Nothing is lost or repeated.
// Configuration: APB-style writes on cfg_*, register i at byte address 4*i;
// write only while no pixel is in flight. pready is tied high.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to
// quadrant 0, skews 0, width and height 1, crop origin 0.
module three_shear_rotation_mapper #(
  parameter int MAX_DIM    = tsr_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = tsr_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tsr_in_if.sink                          in_px,
  tsr_out_if.source                       out_px,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tsr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tsr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tsr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tsr_pkg::*;

  localparam int NSTG    = 7;
  localparam int DIM_CAP = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
  localparam logic signed [X0_W-1:0] X0_ONE = X0_W'(1);

  // configuration registers
  quad_t                quadrant_r;
  logic [FRAC_BITS:0]   skew_x_r;
  logic [FRAC_BITS:0]   skew_y_r;
  logic [DIM_W-1:0]     src_width_r;
  logic [DIM_W-1:0]     src_height_r;
  logic [CROP_W-1:0]    crop_x_r;
  logic [CROP_W-1:0]    crop_y_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quadrant_r   <= QUAD_NONE;
      skew_x_r     <= '0;
      skew_y_r     <= '0;
      src_width_r  <= DIM_W'(1);
      src_height_r <= DIM_W'(1);
      crop_x_r     <= '0;
      crop_y_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUADRANT:   quadrant_r   <= quad_t'(cfg_pwdata[1:0]);
        REG_SKEW_X:     skew_x_r     <= cfg_pwdata[FRAC_BITS:0];
        REG_SKEW_Y:     skew_y_r     <= cfg_pwdata[FRAC_BITS:0];
        REG_SRC_WIDTH:  src_width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_pwdata[DIM_W-1:0];
        REG_CROP_X:     crop_x_r     <= cfg_pwdata[CROP_W-1:0];
        REG_CROP_Y:     crop_y_r     <= cfg_pwdata[CROP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUADRANT:   cfg_prdata = CFG_DATA_W'(quadrant_r);
      REG_SKEW_X:     cfg_prdata = CFG_DATA_W'(skew_x_r);
      REG_SKEW_Y:     cfg_prdata = CFG_DATA_W'(skew_y_r);
      REG_SRC_WIDTH:  cfg_prdata = CFG_DATA_W'(src_width_r);
      REG_SRC_HEIGHT: cfg_prdata = CFG_DATA_W'(src_height_r);
      REG_CROP_X:     cfg_prdata = CFG_DATA_W'(crop_x_r);
      REG_CROP_Y:     cfg_prdata = CFG_DATA_W'(crop_y_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // stage flow control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_nxt;
  logic [NSTG:1] vld_in;
  logic [NSTG:1] go;

  always_comb begin
    go[NSTG] = !vld_r[NSTG] || out_px.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign vld_in  = {vld_r[NSTG-1:1], in_px.valid};
  assign vld_nxt = (go & vld_in) | (~go & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_px.ready  = go[1];
  assign out_px.valid = vld_r[NSTG];

  // stage 1: clamp and quarter-turn
  logic [DIM_W-1:0]       w_c;
  logic [DIM_W-1:0]       h_c;
  logic signed [X0_W-1:0] w_s;
  logic signed [X0_W-1:0] h_s;
  logic signed [X0_W-1:0] i_s;
  logic signed [X0_W-1:0] j_s;
  logic signed [X0_W-1:0] x0_c;
  logic signed [X0_W-1:0] y0_c;
  logic [DIM_W-1:0]       wr_c;
  logic [DIM_W-1:0]       hr_c;

  assign w_c = (int'(src_width_r) > MAX_DIM) ? DIM_W'(DIM_CAP) : src_width_r;
  assign h_c = (int'(src_height_r) > MAX_DIM) ? DIM_W'(DIM_CAP) : src_height_r;
  assign w_s = $signed(X0_W'(w_c));
  assign h_s = $signed(X0_W'(h_c));
  assign i_s = $signed(X0_W'(in_px.src_x));
  assign j_s = $signed(X0_W'(in_px.src_y));

  always_comb begin
    unique case (quadrant_r)
      QUAD_90: begin
        x0_c = h_s - X0_ONE - j_s;
        y0_c = i_s;
        wr_c = h_c;
        hr_c = w_c;
      end
      QUAD_180: begin
        x0_c = w_s - X0_ONE - i_s;
        y0_c = h_s - X0_ONE - j_s;
        wr_c = w_c;
        hr_c = h_c;
      end
      QUAD_270: begin
        x0_c = j_s;
        y0_c = w_s - X0_ONE - i_s;
        wr_c = h_c;
        hr_c = w_c;
      end
      default: begin
        x0_c = i_s;
        y0_c = j_s;
        wr_c = w_c;
        hr_c = h_c;
      end
    endcase
  end

  logic signed [X0_W-1:0] s1_x0_r;
  logic signed [X0_W-1:0] s1_y0_r;
  logic [DIM_W-1:0]       s1_wr_r;
  logic [DIM_W-1:0]       s1_hr_r;
  logic [PIXEL_BITS-1:0]  s1_pix_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s1_x0_r  <= x0_c;
      s1_y0_r  <= y0_c;
      s1_wr_r  <= wr_c;
      s1_hr_r  <= hr_c;
      s1_pix_r <= in_px.pixel;
    end
  end

  // stage 2: first X shear multiply
  logic [N1_W-1:0]        s2_n1;
  logic signed [S1_W-1:0] s2_sh1;
  logic signed [X0_W-1:0] s2_x0_r;
  logic signed [X0_W-1:0] s2_y0_r;
  logic [DIM_W-1:0]       s2_wr_r;
  logic [DIM_W-1:0]       s2_hr_r;
  logic [PIXEL_BITS-1:0]  s2_pix_r;

  tsr_shear_mul #(
    .FRAC_BITS (FRAC_BITS),
    .SIZE_W    (DIM_W),
    .COORD_W   (X0_W),
    .MARGIN_W  (N1_W),
    .SHIFT_W   (S1_W)
  ) u_shear_x1 (
    .clk      (clk),
    .en       (go[2]),
    .size     (s1_hr_r),
    .coord    (s1_y0_r),
    .skew     (skew_x_r),
    .margin_r (s2_n1),
    .shift_r  (s2_sh1)
  );

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s2_x0_r  <= s1_x0_r;
      s2_y0_r  <= s1_y0_r;
      s2_wr_r  <= s1_wr_r;
      s2_hr_r  <= s1_hr_r;
      s2_pix_r <= s1_pix_r;
    end
  end

  // stage 3: apply first X shear, widen image
  logic signed [X1_W-1:0] s3_x1_r;
  logic [W1_W-1:0]        s3_w1_r;
  logic signed [X0_W-1:0] s3_y0_r;
  logic [DIM_W-1:0]       s3_hr_r;
  logic [PIXEL_BITS-1:0]  s3_pix_r;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s3_x1_r  <= X1_W'(s2_x0_r) + $signed(X1_W'(s2_n1)) - X1_W'(s2_sh1);
      s3_w1_r  <= W1_W'(s2_wr_r) + W1_W'(s2_n1);
      s3_y0_r  <= s2_y0_r;
      s3_hr_r  <= s2_hr_r;
      s3_pix_r <= s2_pix_r;
    end
  end

  // stage 4: Y shear multiply
  logic [N2_W-1:0]        s4_n2;
  logic signed [S2_W-1:0] s4_sh2;
  logic signed [X1_W-1:0] s4_x1_r;
  logic signed [X0_W-1:0] s4_y0_r;
  logic [DIM_W-1:0]       s4_hr_r;
  logic [PIXEL_BITS-1:0]  s4_pix_r;

  tsr_shear_mul #(
    .FRAC_BITS (FRAC_BITS),
    .SIZE_W    (W1_W),
    .COORD_W   (X1_W),
    .MARGIN_W  (N2_W),
    .SHIFT_W   (S2_W)
  ) u_shear_y (
    .clk      (clk),
    .en       (go[4]),
    .size     (s3_w1_r),
    .coord    (s3_x1_r),
    .skew     (skew_y_r),
    .margin_r (s4_n2),
    .shift_r  (s4_sh2)
  );

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s4_x1_r  <= s3_x1_r;
      s4_y0_r  <= s3_y0_r;
      s4_hr_r  <= s3_hr_r;
      s4_pix_r <= s3_pix_r;
    end
  end

  // stage 5: apply Y shear, grow height
  logic signed [Y2_W-1:0] s5_y2_r;
  logic [H2_W-1:0]        s5_h2_r;
  logic signed [X1_W-1:0] s5_x1_r;
  logic [PIXEL_BITS-1:0]  s5_pix_r;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      s5_y2_r  <= Y2_W'(s4_y0_r) + Y2_W'(s4_sh2);
      s5_h2_r  <= H2_W'(s4_hr_r) + H2_W'(s4_n2);
      s5_x1_r  <= s4_x1_r;
      s5_pix_r <= s4_pix_r;
    end
  end

  // stage 6: second X shear multiply
  logic [N3_W-1:0]        s6_n3;
  logic signed [S3_W-1:0] s6_sh3;
  logic signed [Y2_W-1:0] s6_y2_r;
  logic signed [X1_W-1:0] s6_x1_r;
  logic [PIXEL_BITS-1:0]  s6_pix_r;

  tsr_shear_mul #(
    .FRAC_BITS (FRAC_BITS),
    .SIZE_W    (H2_W),
    .COORD_W   (Y2_W),
    .MARGIN_W  (N3_W),
    .SHIFT_W   (S3_W)
  ) u_shear_x2 (
    .clk      (clk),
    .en       (go[6]),
    .size     (s5_h2_r),
    .coord    (s5_y2_r),
    .skew     (skew_x_r),
    .margin_r (s6_n3),
    .shift_r  (s6_sh3)
  );

  always_ff @(posedge clk) begin
    if (go[6]) begin
      s6_y2_r  <= s5_y2_r;
      s6_x1_r  <= s5_x1_r;
      s6_pix_r <= s5_pix_r;
    end
  end

  // stage 7: apply second X shear and crop origin, output register
  logic [OUT_W-1:0]      dx_nxt;
  logic [OUT_W-1:0]      dy_nxt;
  logic [OUT_W-1:0]      out_dx_r;
  logic [OUT_W-1:0]      out_dy_r;
  logic [PIXEL_BITS-1:0] out_pix_r;

  assign dx_nxt = OUT_W'(s6_x1_r) + OUT_W'(s6_n3) - OUT_W'(s6_sh3) - OUT_W'(crop_x_r);
  assign dy_nxt = OUT_W'(s6_y2_r) - OUT_W'(crop_y_r);

  always_ff @(posedge clk) begin
    if (go[7]) begin
      out_dx_r  <= dx_nxt;
      out_dy_r  <= dy_nxt;
      out_pix_r <= s6_pix_r;
    end
  end

  assign out_px.dest_x    = $signed(out_dx_r);
  assign out_px.dest_y    = $signed(out_dy_r);
  assign out_px.pixel_out = out_pix_r;
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for three_shear_rotation_mapper: drives random and corner pixels
// under APB register settings and checks each mapped destination. Depends on tsr_pkg, tsr_if.
module tb;
  import tsr_pkg::*;

  localparam int SKEW_W      = FRAC_BITS_DEF + 1;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int HOLD_CYCLES = 60;
  localparam int LIMIT       = 300000;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    quad_t             quad;
    logic [SKEW_W-1:0] skew_x;
    logic [SKEW_W-1:0] skew_y;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CROP_W-1:0] crop_x;
    logic [CROP_W-1:0] crop_y;
  } map_regs_t;

  typedef struct packed {
    logic [OUT_W-1:0]          dx;
    logic [OUT_W-1:0]          dy;
    logic [PIXEL_BITS_DEF-1:0] pix;
  } dest_t;

  class dest_scoreboard;
    map_regs_t regs;
    dest_t     dest_queue[$];
    int        errors;

    function new();
      regs.quad   = QUAD_NONE;
      regs.skew_x = '0;
      regs.skew_y = '0;
      regs.width  = DIM_W'(1);
      regs.height = DIM_W'(1);
      regs.crop_x = '0;
      regs.crop_y = '0;
      errors      = 0;
    endfunction

    function void apply_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_QUADRANT:   regs.quad   = quad_t'(val[1:0]);
        REG_SKEW_X:     regs.skew_x = val[SKEW_W-1:0];
        REG_SKEW_Y:     regs.skew_y = val[SKEW_W-1:0];
        REG_SRC_WIDTH:  regs.width  = val[DIM_W-1:0];
        REG_SRC_HEIGHT: regs.height = val[DIM_W-1:0];
        REG_CROP_X:     regs.crop_x = val[CROP_W-1:0];
        REG_CROP_Y:     regs.crop_y = val[CROP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint shift_of(longint c, longint s);
      return (c * s) >>> FRAC_BITS_DEF;
    endfunction

    function longint margin_of(longint size, longint s);
      return (size * s + (longint'(1) << (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    endfunction

    function dest_t map_pixel(logic [COORD_IN_W-1:0] sx, logic [COORD_IN_W-1:0] sy,
                              logic [PIXEL_BITS_DEF-1:0] pix);
      longint w, h, i, j, kx, ky, x, y, wr, hr, n1, n2, n3, w1, h2;
      dest_t d;
      w  = (regs.width > MAX_DIM_DEF) ? MAX_DIM_DEF : regs.width;
      h  = (regs.height > MAX_DIM_DEF) ? MAX_DIM_DEF : regs.height;
      i  = sx;
      j  = sy;
      kx = regs.skew_x;
      ky = regs.skew_y;
      case (regs.quad)
        QUAD_90: begin
          x = h - 1 - j; y = i; wr = h; hr = w;
        end
        QUAD_180: begin
          x = w - 1 - i; y = h - 1 - j; wr = w; hr = h;
        end
        QUAD_270: begin
          x = j; y = w - 1 - i; wr = h; hr = w;
        end
        default: begin
          x = i; y = j; wr = w; hr = h;
        end
      endcase
      n1 = margin_of(hr, kx);
      x  = x + n1 - shift_of(y, kx);
      w1 = wr + n1;
      n2 = margin_of(w1, ky);
      y  = y + shift_of(x, ky);
      h2 = hr + n2;
      n3 = margin_of(h2, kx);
      x  = x + n3 - shift_of(y, kx);
      x  = x - longint'(regs.crop_x);
      y  = y - longint'(regs.crop_y);
      d.dx  = x[OUT_W-1:0];
      d.dy  = y[OUT_W-1:0];
      d.pix = pix;
      return d;
    endfunction

    function void note_pixel(logic [COORD_IN_W-1:0] sx, logic [COORD_IN_W-1:0] sy,
                             logic [PIXEL_BITS_DEF-1:0] pix);
      dest_queue.push_back(map_pixel(sx, sy, pix));
    endfunction

    function void check_dest(logic [OUT_W-1:0] dx, logic [OUT_W-1:0] dy,
                             logic [PIXEL_BITS_DEF-1:0] pix);
      dest_t want;
      if (dest_queue.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: x=%0d y=%0d px=%h", $signed(dx), $signed(dy), pix);
        return;
      end
      want = dest_queue.pop_front();
      if (want.dx !== dx || want.dy !== dy || want.pix !== pix) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want x=%0d y=%0d px=%h, got x=%0d y=%0d px=%h",
                   $signed(want.dx), $signed(want.dy), want.pix,
                   $signed(dx), $signed(dy), pix);
      end
    endfunction

    function int pending();
      return dest_queue.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  bit                    hold_req = 1'b0;
  int                    cycles = 0;
  dest_scoreboard        sb = new();

  tsr_in_if  in_px();
  tsr_out_if out_px();

  three_shear_rotation_mapper u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_px       (in_px),
    .out_px      (out_px),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_px.valid && out_px.ready)
      sb.check_dest(out_px.dest_x, out_px.dest_y, out_px.pixel_out);
  end

  // receiver: long hold on request, otherwise a changing stall pattern
  initial begin
    int hold_cnt, mode, mode_left, tick;
    hold_cnt     = 0;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_px.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        out_px.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0:       out_px.ready <= 1'b1;
          1:       out_px.ready <= ($urandom_range(0, 3) != 0);
          default: out_px.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.apply_write(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] quad, logic [31:0] kx, logic [31:0] ky,
                            logic [31:0] w, logic [31:0] h, logic [31:0] cx, logic [31:0] cy);
    cfg_write(REG_QUADRANT, quad);
    cfg_write(REG_SKEW_X, kx);
    cfg_write(REG_SKEW_Y, ky);
    cfg_write(REG_SRC_WIDTH, w);
    cfg_write(REG_SRC_HEIGHT, h);
    cfg_write(REG_CROP_X, cx);
    cfg_write(REG_CROP_Y, cy);
    cfg_write(REG_UNMAPPED, $urandom());
  endtask

  task automatic send_pixel(logic [COORD_IN_W-1:0] sx, logic [COORD_IN_W-1:0] sy,
                            logic [PIXEL_BITS_DEF-1:0] pix);
    in_px.valid <= 1'b1;
    in_px.src_x <= sx;
    in_px.src_y <= sy;
    in_px.pixel <= pix;
    do @(posedge clk); while (!in_px.ready);
    sb.note_pixel(sx, sy, pix);
    @(negedge clk);
  endtask

  task automatic send_corners();
    send_pixel(11'd0, 11'd0, 32'h0000_0000);
    send_pixel(11'd2047, 11'd0, 32'hFFFF_FFFF);
    send_pixel(11'd0, 11'd2047, 32'hAAAA_AAAA);
    send_pixel(11'd2047, 11'd2047, 32'h5555_5555);
  endtask

  // hold valid low until every transfer in flight has come out
  task automatic wait_drained();
    in_px.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    @(negedge clk);
  endtask

  function automatic logic [COORD_IN_W-1:0] pick_coord(int dim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 3 || dim == 0) return COORD_IN_W'($urandom_range(0, 2047));
    return COORD_IN_W'($urandom_range(0, ((dim > MAX_DIM_DEF) ? MAX_DIM_DEF : dim) - 1));
  endfunction

  function automatic logic [31:0] pick_skew();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 32'd65536;
      2:       return 32'h1FFFF;
      3:       return $urandom();
      4:       return $urandom_range(0, 4095);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return MAX_DIM_DEF;
      2:       return $urandom_range(MAX_DIM_DEF + 1, 4095);
      3:       return $urandom();
      4:       return $urandom_range(1, 64);
      default: return $urandom_range(1, MAX_DIM_DEF);
    endcase
  endfunction

  function automatic logic [31:0] pick_crop();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32'd16383;
      2:       return $urandom();
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  task automatic run_phase(bit no_gap, bit mid_pause);
    int left, gap;
    left = $urandom_range(1, 24);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      send_pixel(pick_coord(sb.regs.width), pick_coord(sb.regs.height), $urandom());
      left--;
      if (mid_pause && k == PHASE_ITEMS / 2) begin
        wait_drained();
      end else if (left == 0) begin
        left = $urandom_range(1, 24);
        gap  = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          in_px.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_px.valid = 1'b0;
    in_px.src_x = '0;
    in_px.src_y = '0;
    in_px.pixel = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_corners();
    wait_drained();
    set_config(32'(QUAD_90), 32'd65536, 32'd65536, MAX_DIM_DEF, MAX_DIM_DEF,
               32'd16383, 32'd16383);
    send_corners();
    send_pixel(11'd1000, 11'd17, $urandom());
    wait_drained();
    set_config(32'(QUAD_180), 0, 0, 32'd4095, 0, 0, 0);
    send_corners();
    send_pixel(11'd3, 11'd5, $urandom());
    wait_drained();
    set_config(32'(QUAD_270), 32'h1FFFF, 32'd1, 32'd16, 32'd3000, 0, 32'd9000);
    send_corners();
    send_pixel(11'd5, 11'd2040, $urandom());
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        set_config(32'(QUAD_270), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      else if (ph == 1)
        set_config(32'(QUAD_NONE), 0, 0, 0, 0, 0, 0);
      else
        set_config(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 3),
                   pick_skew(), pick_skew(), pick_dim(), pick_dim(), pick_crop(), pick_crop());
      if (ph == 2)
        hold_req = 1'b1;
      run_phase(ph % 3 == 2, ph == 5);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
